### hdl/i2cdw_pkg.sv
// i2cdw_pkg: shared types, codes and constants of the i2c display write frame block
// no dependencies; taken in by every other file through scoped names
`timescale 1ns / 1ps
`default_nettype none

package i2cdw_pkg;

   // field widths
   localparam int OP_W      = 2;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 7;
   localparam int NACK_W    = 3;
   localparam int POS_W     = 5;
   localparam int BYTE_NUM_W = 2;

   // request codes on the op field
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_CMD  = 2'd1;
   localparam logic [OP_W-1:0] OP_DATA = 2'd2;

   // control bytes
   localparam logic [BYTE_W-1:0] CTRL_CMD  = 8'h00;
   localparam logic [BYTE_W-1:0] CTRL_DATA = 8'h40;

   // bit timing inside one byte: 16 data ticks then 2 ack ticks
   localparam logic [POS_W-1:0] ACK_HI_POS = 5'd17;
   localparam logic [BYTE_NUM_W-1:0] LAST_BYTE = 2'd2;

   // configuration
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_SLAVE_ADDRESS = 1'b0;
   localparam logic [ADDR_W-1:0] SLAVE_ADDRESS_RESET = 7'd60;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_CMD  = 2'd1,
      KIND_DATA = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload;
      logic              sda_in;
   } item_type;

   typedef struct packed {
      logic              valid;
      item_type          item;
   } slot_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_START_HI = 7'b0000010,
      ST_START_LO = 7'b0000100,
      ST_SHIFT    = 7'b0001000,
      ST_STOP_LO  = 7'b0010000,
      ST_STOP_HI  = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              sda_drive;
      logic              busy_res;
      logic              frame_done;
      logic [NACK_W-1:0] nack_mask;
      logic              request_dropped;
   } result_type;

endpackage

`default_nettype wire

### hdl/i2cdw_if.sv
// i2cdw_req_if and i2cdw_rsp_if: valid/ready channels of the frame block
// depends on i2cdw_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface i2cdw_req_if;
   logic                          valid;
   logic                          ready;
   logic [i2cdw_pkg::OP_W-1:0]    op;
   logic [i2cdw_pkg::BYTE_W-1:0]  payload;
   logic                          sda_in;

   modport source (output valid, output op, output payload, output sda_in, input ready);
   modport sink   (input valid, input op, input payload, input sda_in, output ready);
endinterface

interface i2cdw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          scl;
   logic                          sda;
   logic                          sda_drive;
   logic                          busy_res;
   logic                          frame_done;
   logic [i2cdw_pkg::NACK_W-1:0]  nack_mask;
   logic                          request_dropped;

   modport source (output valid, output scl, output sda, output sda_drive, output busy_res,
                   output frame_done, output nack_mask, output request_dropped,
                   input ready);
   modport sink   (input valid, input scl, input sda, input sda_drive, input busy_res,
                   input frame_done, input nack_mask, input request_dropped,
                   output ready);
endinterface

`default_nettype wire

### hdl/i2cdw_front.sv
// i2cdw_front: takes input transfers and classifies the op code for the queue
// depends on i2cdw_pkg and i2cdw_req_if
`timescale 1ns / 1ps
`default_nettype none

module i2cdw_front (
   i2cdw_req_if.sink              req_ch,
   input  wire logic              queue_full,
   output i2cdw_pkg::slot_type    push
);

   i2cdw_pkg::kind_type kind;

   // unused op code counts as a plain tick
   always_comb begin
      case (req_ch.op)
         i2cdw_pkg::OP_CMD:  kind = i2cdw_pkg::KIND_CMD;
         i2cdw_pkg::OP_DATA: kind = i2cdw_pkg::KIND_DATA;
         default:            kind = i2cdw_pkg::KIND_TICK;
      endcase
   end

   assign req_ch.ready      = !queue_full;
   assign push.valid        = req_ch.valid && !queue_full;
   assign push.item.kind    = kind;
   assign push.item.payload = req_ch.payload;
   assign push.item.sda_in  = req_ch.sda_in;

endmodule

`default_nettype wire

### hdl/i2cdw_queue.sv
// i2cdw_queue: short first-in first-out store between front and back
// depends on i2cdw_pkg for the slot and item types
`timescale 1ns / 1ps
`default_nettype none

module i2cdw_queue #(
   parameter int DEPTH = i2cdw_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire i2cdw_pkg::slot_type push,
   output logic                   full,
   input  wire logic              pop,
   output i2cdw_pkg::slot_type    head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   i2cdw_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

### hdl/i2cdw_back.sv
// i2cdw_back: frame sequencer, one tick per queued item, with the result register
// depends on i2cdw_pkg and i2cdw_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module i2cdw_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire i2cdw_pkg::slot_type                head,
   output logic                                    pop,
   input  wire logic [i2cdw_pkg::ADDR_W-1:0]       slave_address,
   i2cdw_rsp_if.source                             rsp_ch
);

   i2cdw_pkg::state_type state_ff, state_in, state_eff;
   logic [i2cdw_pkg::BYTE_W-1:0]     shift_ff, shift_in;
   logic [i2cdw_pkg::BYTE_W-1:0]     held_ff, held_in;
   logic                             is_data_ff, is_data_in;
   logic [i2cdw_pkg::BYTE_NUM_W-1:0] byte_ff, byte_in;
   logic [i2cdw_pkg::NACK_W-1:0]     ack_ff, ack_in;
   logic [i2cdw_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   i2cdw_pkg::result_type            res_ff, res_in;
   logic                             is_req, start;

   // one tick per cycle while the result register is free or being drained
   assign pop = head.valid && (!rsp_valid_ff || rsp_ch.ready);

   assign is_req = (head.item.kind == i2cdw_pkg::KIND_CMD) ||
                   (head.item.kind == i2cdw_pkg::KIND_DATA);
   assign start  = is_req && (state_ff == i2cdw_pkg::ST_IDLE);

   always_comb begin
      state_eff  = start ? i2cdw_pkg::ST_START_HI : state_ff;
      state_in   = state_eff;
      shift_in   = shift_ff;
      held_in    = held_ff;
      is_data_in = is_data_ff;
      byte_in    = byte_ff;
      ack_in     = ack_ff;
      pos_in     = pos_ff;

      res_in.scl             = 1'b1;
      res_in.sda             = 1'b1;
      res_in.sda_drive       = 1'b1;
      res_in.busy_res        = (state_eff != i2cdw_pkg::ST_IDLE);
      res_in.frame_done      = 1'b0;
      res_in.nack_mask       = '0;
      res_in.request_dropped = is_req && (state_ff != i2cdw_pkg::ST_IDLE);

      if (start) begin
         held_in    = head.item.payload;
         is_data_in = (head.item.kind == i2cdw_pkg::KIND_DATA);
         byte_in    = '0;
         ack_in     = '0;
         shift_in   = {slave_address, 1'b0};
      end

      case (state_eff)
         i2cdw_pkg::ST_IDLE: begin
            state_in = i2cdw_pkg::ST_IDLE;
         end
         i2cdw_pkg::ST_START_HI: begin
            state_in = i2cdw_pkg::ST_START_LO;
         end
         i2cdw_pkg::ST_START_LO: begin
            res_in.sda = 1'b0;
            pos_in     = '0;
            state_in   = i2cdw_pkg::ST_SHIFT;
         end
         i2cdw_pkg::ST_SHIFT: begin
            res_in.scl = pos_ff[0];
            pos_in     = pos_ff + 1'b1;
            if (!pos_ff[i2cdw_pkg::POS_W-1]) begin
               // data bit, msb first; shift after the high half
               res_in.sda = shift_ff[i2cdw_pkg::BYTE_W-1];
               if (pos_ff[0]) begin
                  shift_in = {shift_ff[i2cdw_pkg::BYTE_W-2:0], 1'b0};
               end
            end else begin
               // ack slot, line released
               res_in.sda       = 1'b1;
               res_in.sda_drive = 1'b0;
               if (pos_ff == i2cdw_pkg::ACK_HI_POS) begin
                  ack_in  = ack_ff | (i2cdw_pkg::NACK_W'(head.item.sda_in) << byte_ff);
                  byte_in = byte_ff + 1'b1;
                  pos_in  = '0;
                  if (byte_ff == '0) begin
                     shift_in = is_data_ff ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD;
                  end else begin
                     shift_in = held_ff;
                  end
                  if (byte_ff == i2cdw_pkg::LAST_BYTE) begin
                     state_in = i2cdw_pkg::ST_STOP_LO;
                  end
               end
            end
         end
         i2cdw_pkg::ST_STOP_LO: begin
            res_in.scl = 1'b0;
            res_in.sda = 1'b0;
            state_in   = i2cdw_pkg::ST_STOP_HI;
         end
         i2cdw_pkg::ST_STOP_HI: begin
            res_in.sda = 1'b0;
            state_in   = i2cdw_pkg::ST_FINISH;
         end
         i2cdw_pkg::ST_FINISH: begin
            res_in.frame_done = 1'b1;
            res_in.nack_mask  = ack_ff;
            state_in          = i2cdw_pkg::ST_IDLE;
         end
         default: begin
            state_in = i2cdw_pkg::ST_IDLE;
         end
      endcase

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2cdw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         shift_ff   <= shift_in;
         held_ff    <= held_in;
         is_data_ff <= is_data_in;
         byte_ff    <= byte_in;
         ack_ff     <= ack_in;
         pos_ff     <= pos_in;
         res_ff     <= res_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.scl             = res_ff.scl;
   assign rsp_ch.sda             = res_ff.sda;
   assign rsp_ch.sda_drive       = res_ff.sda_drive;
   assign rsp_ch.busy_res        = res_ff.busy_res;
   assign rsp_ch.frame_done      = res_ff.frame_done;
   assign rsp_ch.nack_mask       = res_ff.nack_mask;
   assign rsp_ch.request_dropped = res_ff.request_dropped;

endmodule

`default_nettype wire

### hdl/i2c_display_write_frame.sv
// i2c_display_write_frame: top level of the i2c write frame master, one tick per transfer
// depends on i2cdw_pkg, i2cdw_if, i2cdw_front, i2cdw_queue and i2cdw_back
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  carries
// req_ch    in         op, payload, sda_in: one bit-timing tick per transfer
// rsp_ch    out        scl, sda, sda_drive, busy_res, frame_done, nack_mask, request_dropped
// csr_*     in         apb-style write/read of slave_address at byte address 0
//
// one result per input transfer; a new tick is taken every cycle when nothing stalls
// a taken tick passes the queue stage, then the result register, on its way to rsp_ch
// a frame is 59 ticks from the tick that carries the request; the back sequencer sets the rate
// reset is synchronous; it empties the queue, drops any held result and returns to idle
// a stall on rsp_ch holds the result register; the queue then fills and req_ch.ready falls

module i2c_display_write_frame #(
   parameter int QUEUE_DEPTH = i2cdw_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   i2cdw_req_if.sink                                req_ch,
   i2cdw_rsp_if.source                              rsp_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [i2cdw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [i2cdw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [i2cdw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready
);

   // configuration register
   logic [i2cdw_pkg::ADDR_W-1:0] slave_address_ff, slave_address_in;
   logic                         csr_write;
   logic                         csr_hit;

   // front to queue, queue to back
   i2cdw_pkg::slot_type push;
   i2cdw_pkg::slot_type head;
   logic                queue_full;
   logic                pop;

   // word index is the bit above the byte offset
   assign csr_hit    = (csr_paddr[i2cdw_pkg::CSR_ADDR_W-1] == i2cdw_pkg::REG_SLAVE_ADDRESS);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      slave_address_in = slave_address_ff;
      if (csr_write && csr_hit) begin
         slave_address_in = csr_pwdata[i2cdw_pkg::ADDR_W-1:0];
      end
   end

   // read back; unmapped word reads as zero
   assign csr_prdata = csr_hit
                       ? {{(i2cdw_pkg::CSR_DATA_W - i2cdw_pkg::ADDR_W){1'b0}}, slave_address_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= i2cdw_pkg::SLAVE_ADDRESS_RESET;
      end else begin
         slave_address_ff <= slave_address_in;
      end
   end

   // front: takes each transfer and classifies the op code
   i2cdw_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   // queue: lets the front keep taking ticks while the result side stalls
   i2cdw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   // back: frame sequencer and result register
   i2cdw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .slave_address (slave_address_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule

`default_nettype wire
